// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg)
`endif
`endif

// ===== design/sacc_pkg.sv =====
// Types, codes and helper functions of the switch array command controller.
package sacc_pkg;

	localparam int SWITCHES   = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 1'b1;

	localparam logic [7:0] PULSE_TICKS_RESET = 8'd100;
	localparam logic [7:0] TRAILER           = 8'h05;

	localparam logic [7:0] OP_SHIFT_UP   = 8'h00;
	localparam logic [7:0] OP_SWITCH     = 8'h33;
	localparam logic [7:0] OP_SHIFT_DOWN = 8'haa;
	localparam logic [7:0] OP_READ_STATE = 8'h11;
	localparam logic [7:0] OP_READ_FULL  = 8'h44;
	localparam logic [7:0] OP_READ_NIB_A = 8'hbb;
	localparam logic [7:0] OP_READ_NIB_B = 8'hee;
	localparam logic [7:0] OP_READ_TEMP  = 8'hdd;

	typedef enum logic [1:0] {
		CMD_RX     = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_STEP   = 2'd2,
		CMD_SAMPLE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TX    = 2'd0,
		KIND_START = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// One queued job: up to four result words that share kind, bits and count.
	typedef struct packed {
		kind_t               kind;
		logic [1:0]          last_idx;
		logic [3:0][7:0]     bytes;
		logic [SWITCHES-1:0] bits;
		logic [7:0]          count;
	} job_t;

	function automatic logic [SWITCHES-1:0] drive_pattern(logic [7:0] hi, logic [7:0] lo);
		return {hi[3:0], lo};
	endfunction

	function automatic logic [7:0] shape_high(logic [7:0] v);
		return {4'b0000, v[5:2]};
	endfunction

	function automatic logic [7:0] shape_low(logic [7:0] v);
		return {v[1:0], v[5:0]};
	endfunction

endpackage

// ===== design/sacc_front.sv =====
// Front end: frame parsing, switch state, pulse timing and job building.
module sacc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  sacc_pkg::cmd_t                   command,
	input  logic [7:0]                       rx_byte,
	input  logic [11:0]                      sample,
	input  logic                             cfg_we,
	input  logic [sacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                             job_push,
	output sacc_pkg::job_t                   job
);
	import sacc_pkg::*;

	localparam logic [2:0] POS_ADDR  = 3'd0;
	localparam logic [2:0] POS_HIGH  = 3'd1;
	localparam logic [2:0] POS_LOW   = 3'd2;
	localparam logic [2:0] POS_CHECK = 3'd3;
	localparam logic [2:0] POS_OP    = 3'd4;

	logic [7:0]  panel_q, ticks_cfg_q;
	logic [2:0]  pos_q, pos_d;
	logic        match_q, match_d;
	logic [7:0]  hh_q, hh_d, hl_q, hl_d, sh_q, sh_d, sl_q, sl_d;
	logic        run_q, run_d;
	logic [7:0]  tick_q, tick_d, tick_inc;
	logic [7:0]  op_q, op_d;
	logic [11:0] samp_q, samp_d;
	logic        start_req;
	logic [7:0]  step_next;

	assign tick_inc  = tick_q + 8'd1;
	assign step_next = {2'b00, sl_q[5:0] + 6'd1};

	always_comb begin
		pos_d     = pos_q;
		match_d   = match_q;
		hh_d      = hh_q;
		hl_d      = hl_q;
		sh_d      = sh_q;
		sl_d      = sl_q;
		run_d     = run_q;
		tick_d    = tick_q;
		op_d      = op_q;
		samp_d    = samp_q;
		start_req = 1'b0;
		job_push  = 1'b0;
		job       = '0;
		job.count = op_q;
		if (in_valid && in_ready) begin
			unique case (command)
				CMD_RX: begin
					unique case (pos_q)
						POS_ADDR: begin
							match_d = (rx_byte == panel_q);
							pos_d   = POS_HIGH;
						end
						POS_HIGH: begin
							hh_d  = rx_byte;
							pos_d = POS_LOW;
						end
						POS_LOW: begin
							hl_d  = rx_byte;
							pos_d = POS_CHECK;
						end
						POS_CHECK: begin
							pos_d = POS_OP;
						end
						default: begin
							// Opcode byte; any position past the check byte lands here.
							pos_d = POS_ADDR;
							if (match_q) begin
								unique case (rx_byte) inside
									OP_SHIFT_UP: begin
										hh_d      = shape_high(hl_q);
										hl_d      = shape_low(hl_q);
										start_req = 1'b1;
									end
									OP_SWITCH: begin
										start_req = 1'b1;
									end
									OP_SHIFT_DOWN: begin
										hl_d      = {hh_q[3:0], hl_q[3:0]};
										hh_d      = {4'b0000, hh_q[7:4]};
										start_req = 1'b1;
									end
									OP_READ_STATE: begin
										job_push      = 1'b1;
										job.kind      = KIND_TX;
										job.last_idx  = 2'd2;
										job.bytes[0]  = panel_q;
										job.bytes[1]  = {2'b00, sl_q[5:0]};
										job.bytes[2]  = TRAILER;
									end
									OP_READ_FULL: begin
										job_push      = 1'b1;
										job.kind      = KIND_TX;
										job.last_idx  = 2'd3;
										job.bytes[0]  = panel_q;
										job.bytes[1]  = sh_q;
										job.bytes[2]  = sl_q;
										job.bytes[3]  = TRAILER;
									end
									OP_READ_NIB_A, OP_READ_NIB_B: begin
										job_push      = 1'b1;
										job.kind      = KIND_TX;
										job.last_idx  = 2'd3;
										job.bytes[0]  = panel_q;
										job.bytes[1]  = {sh_q[3:0], sl_q[7:4]};
										job.bytes[2]  = {4'b0000, sl_q[3:0]};
										job.bytes[3]  = TRAILER;
									end
									OP_READ_TEMP: begin
										job_push      = 1'b1;
										job.kind      = KIND_TX;
										job.last_idx  = 2'd1;
										job.bytes[0]  = {4'b0000, samp_q[11:8]};
										job.bytes[1]  = samp_q[7:0];
									end
									default: begin
									end
								endcase
							end
						end
					endcase
				end
				CMD_TICK: begin
					if (run_q) begin
						if (tick_inc == ticks_cfg_q) begin
							// Pulse over: commit the held pattern and count the switch.
							run_d        = 1'b0;
							tick_d       = 8'd0;
							op_d         = op_q + 8'd1;
							sh_d         = hh_q;
							sl_d         = hl_q;
							job_push     = 1'b1;
							job.kind     = KIND_END;
							job.bits     = drive_pattern(hh_q, hl_q);
							job.count    = op_q + 8'd1;
						end else begin
							tick_d = tick_inc;
						end
					end
				end
				CMD_STEP: begin
					hh_d      = shape_high(step_next);
					hl_d      = shape_low(step_next);
					start_req = 1'b1;
				end
				CMD_SAMPLE: begin
					samp_d = sample;
				end
				default: begin
				end
			endcase
			// A switch request only starts a pulse when none is running.
			if (start_req && !run_q) begin
				run_d    = 1'b1;
				job_push = 1'b1;
				job.kind = KIND_START;
				job.bits = drive_pattern(hh_d, hl_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_q     <= 8'd0;
			ticks_cfg_q <= PULSE_TICKS_RESET;
			pos_q       <= POS_ADDR;
			match_q     <= 1'b0;
			hh_q        <= 8'd0;
			hl_q        <= 8'd0;
			sh_q        <= 8'd0;
			sl_q        <= 8'd0;
			run_q       <= 1'b0;
			tick_q      <= 8'd0;
			op_q        <= 8'd0;
			samp_q      <= 12'd0;
		end else begin
			pos_q   <= pos_d;
			match_q <= match_d;
			hh_q    <= hh_d;
			hl_q    <= hl_d;
			sh_q    <= sh_d;
			sl_q    <= sl_d;
			run_q   <= run_d;
			tick_q  <= tick_d;
			op_q    <= op_d;
			samp_q  <= samp_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PANEL_ADDRESS: panel_q     <= cfg_wdata;
					CFG_PULSE_TICKS:   ticks_cfg_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== design/sacc_fifo.sv =====
// Short job queue between the front end and the output sequencer.
module sacc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sacc_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output sacc_pkg::job_t pop_data,
	output logic           empty
);
	import sacc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/sacc_back.sv =====
// Output sequencer: unrolls one queued job into its result words.
module sacc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  sacc_pkg::job_t                  job,
	output logic                            job_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sacc_pkg::kind_t                 kind,
	output logic [7:0]                      tx_byte,
	output logic [sacc_pkg::SWITCHES-1:0]   drive_bits,
	output logic [7:0]                      switch_count,
	output logic                            last
);
	import sacc_pkg::*;

	job_t       cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       taken;

	assign out_valid    = busy_q;
	assign kind         = cur_q.kind;
	assign tx_byte      = cur_q.bytes[idx_q];
	assign drive_bits   = cur_q.bits;
	assign switch_count = cur_q.count;
	assign last         = (idx_q == cur_q.last_idx);
	assign taken        = busy_q && out_ready;
	// Load the next job when empty or as the last word of the current job leaves.
	assign job_pop      = job_valid && (!busy_q || (taken && last));

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (taken) begin
			if (last) begin
				busy_q <= 1'b0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/switch_array_command_controller.sv =====
// Top level of the switch array command controller.
`include "assert_macros.svh"

// Controls a 12-switch latching array from five-byte serial frames (address, high data,
// low data, an ignored check byte, opcode) plus pulse timer ticks, a step button and
// temperature samples, all arriving as words on the slave stream. Every input word is
// taken by the front end, which updates the frame position, held and status bytes,
// pulse timer and switch count, and turns the word into a job of zero to four result
// words; back-to-back input words are accepted while the job queue has room. The
// output sequencer sends one result word per cycle while m_tready is high, so a status
// read takes up to four output words and a pulse event one; the queue depth (QUEUE_DEPTH
// jobs) sets how far the input may run ahead of a stalled or busy output. A word with no
// result (data bytes, ignored ticks, samples) occupies no queue slot.
// Configuration writes land at once and belong to idle periods.
module switch_array_command_controller #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sacc_pkg::IN_DATA_W-1:0]   s_tdata,   // rx_byte[7:0], sample[19:8], zero
	input  logic [1:0]                       s_tuser,   // command[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sacc_pkg::OUT_DATA_W-1:0]  m_tdata,   // tx_byte, drive_bits, count, zero
	output logic [1:0]                       m_tuser,   // kind[1:0]
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [sacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import sacc_pkg::*;

	logic                job_push, q_full, q_empty, q_pop;
	job_t                job_in, job_out;
	kind_t               out_kind;
	logic [7:0]          out_tx, out_count;
	logic [SWITCHES-1:0] out_bits;

	// The front end accepts whenever the queue can take a job.
	assign s_tready = !q_full;

	sacc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.command   (cmd_t'(s_tuser)),
		.rx_byte   (s_tdata[7:0]),
		.sample    (s_tdata[19:8]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.job_push  (job_push),
		.job       (job_in)
	);

	sacc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (job_out),
		.empty     (q_empty)
	);

	sacc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (!q_empty),
		.job          (job_out),
		.job_pop      (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.kind         (out_kind),
		.tx_byte      (out_tx),
		.drive_bits   (out_bits),
		.switch_count (out_count),
		.last         (m_tlast)
	);

	// Output word layout, from the lowest bit up.
	assign m_tdata = {4'b0000, out_count, out_bits, out_tx};
	assign m_tuser = out_kind;

	// A job is only built on an accepted word, which needs queue room.
	`ASSERT_IMPL(a_push_has_room, clk, arst_n, job_push, !q_full, "job pushed into full queue")
	// Pulse events are single-word jobs.
	`ASSERT_IMPL(a_pulse_single, clk, arst_n, m_tvalid && (out_kind != KIND_TX), m_tlast,
		"pulse event word not marked last")
	// Serial answer words carry no drive pattern.
	`ASSERT_IMPL(a_tx_no_bits, clk, arst_n, m_tvalid && (out_kind == KIND_TX),
		out_bits == '0, "serial word carries drive bits")
	// A job leaving the queue is on the output in the next cycle.
	`ASSERT_NEXT(a_pop_shows, clk, arst_n, q_pop, m_tvalid, "popped job not presented")

endmodule
